// ----- hw/rtl/bitcoin_tx_length_parser_macros.svh -----
// assertion macros for the transaction length parser
`ifndef BITCOIN_TX_LENGTH_PARSER_MACROS_SVH
`define BITCOIN_TX_LENGTH_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define BTX_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define BTX_ASSERT_NEVER(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");
`else
`define BTX_ASSERT(label, clk, rst_n, prop)
`define BTX_ASSERT_NEVER(label, clk, rst_n, prop)
`endif

`endif

// ----- hw/rtl/btxlp_pkg.sv -----
// types and constants shared by the transaction length parser
package btxlp_pkg;

	localparam int unsigned MAX_TX_BYTES_DEF = 65536;
	localparam int unsigned LEN_W = 17;
	localparam int unsigned IN_TDATA_W = 8;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [7:0] VARINT_PFX_2 = 8'hfd;
	localparam logic [7:0] VARINT_PFX_4 = 8'hfe;
	localparam logic [3:0] VARINT_LEN_2 = 4'd2;
	localparam logic [3:0] VARINT_LEN_4 = 4'd4;
	localparam logic [3:0] VARINT_LEN_8 = 4'd8;

	localparam logic [63:0] VERSION_BYTES  = 64'd4;
	localparam logic [63:0] IN_HEAD_BYTES  = 64'd36;
	localparam logic [63:0] IN_SEQ_BYTES   = 64'd4;
	localparam logic [63:0] OUT_AMT_BYTES  = 64'd8;
	localparam logic [63:0] LOCKTIME_BYTES = 64'd4;

	typedef enum logic [3:0] {
		PH_VERSION,
		PH_IN_COUNT,
		PH_IN_HEAD,
		PH_IN_SLEN,
		PH_IN_SCRIPT,
		PH_IN_SEQ,
		PH_OUT_COUNT,
		PH_OUT_AMT,
		PH_OUT_SLEN,
		PH_OUT_SCRIPT,
		PH_LOCKTIME,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic             tx_valid;
		logic [LEN_W-1:0] tx_length;
	} result_t;

endpackage

// ----- hw/rtl/btxlp_core.sv -----
// parse state and per-byte next-state logic
`include "bitcoin_tx_length_parser_macros.svh"

module btxlp_core #(
	parameter int unsigned MAX_TX_BYTES = btxlp_pkg::MAX_TX_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output btxlp_pkg::result_t  res
);
	import btxlp_pkg::*;

	localparam int unsigned BUF_W = $clog2(MAX_TX_BYTES + 1);
	localparam logic [BUF_W-1:0] BUF_MAX = BUF_W'(MAX_TX_BYTES);

	phase_t           phase_q, phase_n;
	logic [63:0]      fixed_q, fixed_n;
	logic [63:0]      vval_q, vval_n;
	logic [3:0]       vleft_q, vleft_n;
	logic [2:0]       vpos_q, vpos_n;
	logic [63:0]      items_q, items_n;
	logic [LEN_W-1:0] consumed_q, consumed_n;
	logic [BUF_W-1:0] buf_q, buf_n;
	logic             done_q, done_n;
	logic             ovf_q, ovf_n;

	logic        vfinish;
	logic [63:0] vres;
	logic [63:0] vacc;
	logic        do_ff;
	phase_t      ff_phase;

	assign vacc = vval_q | ({56'b0, data_byte} << {vpos_q, 3'b000});

	always_comb begin
		phase_n    = phase_q;
		fixed_n    = fixed_q;
		vval_n     = vval_q;
		vleft_n    = vleft_q;
		vpos_n     = vpos_q;
		items_n    = items_q;
		consumed_n = consumed_q;
		buf_n      = buf_q;
		done_n     = done_q;
		ovf_n      = ovf_q;
		vfinish    = 1'b0;
		vres       = '0;
		do_ff      = 1'b0;
		ff_phase   = phase_q;

		if (buf_q >= BUF_MAX) begin
			ovf_n = 1'b1;
		end else begin
			buf_n = buf_q + BUF_W'(1);
		end

		if (!ovf_n && !done_q) begin
			consumed_n = consumed_q + LEN_W'(1);
			case (phase_q)
				PH_IN_COUNT, PH_IN_SLEN, PH_OUT_COUNT, PH_OUT_SLEN: begin
					if (vleft_q == 4'd0) begin
						if (data_byte < VARINT_PFX_2) begin
							vfinish = 1'b1;
							vres    = {56'b0, data_byte};
						end else begin
							vleft_n = (data_byte == VARINT_PFX_2) ? VARINT_LEN_2 :
								(data_byte == VARINT_PFX_4) ? VARINT_LEN_4 : VARINT_LEN_8;
							vpos_n  = 3'd0;
							vval_n  = '0;
						end
					end else begin
						vval_n  = vacc;
						vpos_n  = vpos_q + 3'd1;
						vleft_n = vleft_q - 4'd1;
						if (vleft_q == 4'd1) begin
							vfinish = 1'b1;
							vres    = vacc;
						end
					end
					if (vfinish) begin
						case (phase_q)
							PH_IN_COUNT: begin
								items_n = vres;
								if (vres != '0) begin
									phase_n = PH_IN_HEAD;
									fixed_n = IN_HEAD_BYTES;
								end else begin
									phase_n = PH_OUT_COUNT;
									vval_n  = '0;
									vleft_n = '0;
									vpos_n  = '0;
								end
							end
							PH_IN_SLEN: begin
								phase_n = PH_IN_SCRIPT;
								fixed_n = vres;
								if (vres == '0) begin
									do_ff    = 1'b1;
									ff_phase = PH_IN_SCRIPT;
								end
							end
							PH_OUT_COUNT: begin
								items_n = vres;
								if (vres != '0) begin
									phase_n = PH_OUT_AMT;
									fixed_n = OUT_AMT_BYTES;
								end else begin
									phase_n = PH_LOCKTIME;
									fixed_n = LOCKTIME_BYTES;
								end
							end
							default: begin
								phase_n = PH_OUT_SCRIPT;
								fixed_n = vres;
								if (vres == '0) begin
									do_ff    = 1'b1;
									ff_phase = PH_OUT_SCRIPT;
								end
							end
						endcase
					end
				end
				PH_DONE: begin
				end
				default: begin
					fixed_n = (fixed_q != '0) ? fixed_q - 64'd1 : '0;
					do_ff   = (fixed_q[63:1] == '0);
				end
			endcase

			if (do_ff) begin
				case (ff_phase)
					PH_VERSION: begin
						phase_n = PH_IN_COUNT;
						vval_n  = '0;
						vleft_n = '0;
						vpos_n  = '0;
					end
					PH_IN_HEAD: begin
						phase_n = PH_IN_SLEN;
						vval_n  = '0;
						vleft_n = '0;
						vpos_n  = '0;
					end
					PH_IN_SCRIPT: begin
						phase_n = PH_IN_SEQ;
						fixed_n = IN_SEQ_BYTES;
					end
					PH_IN_SEQ: begin
						items_n = items_q - 64'd1;
						if (items_q != 64'd1) begin
							phase_n = PH_IN_HEAD;
							fixed_n = IN_HEAD_BYTES;
						end else begin
							phase_n = PH_OUT_COUNT;
							vval_n  = '0;
							vleft_n = '0;
							vpos_n  = '0;
						end
					end
					PH_OUT_AMT: begin
						phase_n = PH_OUT_SLEN;
						vval_n  = '0;
						vleft_n = '0;
						vpos_n  = '0;
					end
					PH_OUT_SCRIPT: begin
						items_n = items_q - 64'd1;
						if (items_q != 64'd1) begin
							phase_n = PH_OUT_AMT;
							fixed_n = OUT_AMT_BYTES;
						end else begin
							phase_n = PH_LOCKTIME;
							fixed_n = LOCKTIME_BYTES;
						end
					end
					PH_LOCKTIME: begin
						phase_n = PH_DONE;
						done_n  = 1'b1;
					end
					default: begin
						phase_n = PH_DONE;
					end
				endcase
			end
		end
	end

	always_comb begin
		res.tx_valid  = done_n && !ovf_n;
		res.tx_length = res.tx_valid ? consumed_n : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_VERSION;
			fixed_q    <= VERSION_BYTES;
			vval_q     <= '0;
			vleft_q    <= '0;
			vpos_q     <= '0;
			items_q    <= '0;
			consumed_q <= '0;
			buf_q      <= '0;
			done_q     <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				phase_q    <= PH_VERSION;
				fixed_q    <= VERSION_BYTES;
				vval_q     <= '0;
				vleft_q    <= '0;
				vpos_q     <= '0;
				items_q    <= '0;
				consumed_q <= '0;
				buf_q      <= '0;
				done_q     <= 1'b0;
				ovf_q      <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				fixed_q    <= fixed_n;
				vval_q     <= vval_n;
				vleft_q    <= vleft_n;
				vpos_q     <= vpos_n;
				items_q    <= items_n;
				consumed_q <= consumed_n;
				buf_q      <= buf_n;
				done_q     <= done_n;
				ovf_q      <= ovf_n;
			end
		end
	end

	// fresh buffer starts from the version field
	`BTX_ASSERT(a_last_restarts, clk, arst_n, step && last_byte |=> phase_q == PH_VERSION && consumed_q == '0 && !done_q)
	`BTX_ASSERT(a_done_phase, clk, arst_n, done_q |-> phase_q == PH_DONE)
	`BTX_ASSERT(a_ovf_saturated, clk, arst_n, ovf_q |-> buf_q == BUF_MAX)

endmodule

// ----- hw/rtl/bitcoin_tx_length_parser.sv -----
// an accepted byte is registered in the input stage; the parse state takes it when
// that stage advances, and for the last byte of a buffer the result is registered to m_tdata in that step
// throughput: one byte per cycle, set by the parse step, unless a last byte waits for a stalled result
// a stalled result holds while further bytes of the next buffer keep flowing
// reset: arst_n clears the parse state to the version field, both stages empty
// top level of the legacy transaction length parser
`include "bitcoin_tx_length_parser_macros.svh"

module bitcoin_tx_length_parser #(
	parameter int unsigned MAX_TX_BYTES = btxlp_pkg::MAX_TX_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [btxlp_pkg::IN_TDATA_W-1:0]    s_tdata,  // data_byte
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [btxlp_pkg::OUT_TDATA_W-1:0]   m_tdata   // tx_valid, tx_length, zero pad
);
	import btxlp_pkg::*;

	localparam int unsigned PAD_W = OUT_TDATA_W - LEN_W - 1;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_free;
	logic       advance;
	logic       out_valid_q;
	result_t    res_q;
	result_t    res_c;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	btxlp_core #(
		.MAX_TX_BYTES(MAX_TX_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res       (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {PAD_W'(0), res_q.tx_length, res_q.tx_valid};

	// a result only comes from the last byte of a buffer
	`BTX_ASSERT(a_out_from_last, clk, arst_n, $rose(out_valid_q) |-> $past(advance && last_s1))
	`BTX_ASSERT_NEVER(a_len_when_invalid, clk, arst_n, out_valid_q && !res_q.tx_valid && res_q.tx_length != '0)
	`BTX_ASSERT(a_s1_holds, clk, arst_n, valid_s1 && !advance |=> valid_s1 && $stable(data_s1) && $stable(last_s1))

endmodule

// ----- dv/bitcoin_tx_length_parser_tb.sv -----
// testbench for the legacy transaction length parser with a parse predictor
module bitcoin_tx_length_parser_tb;

	import btxlp_pkg::*;

	localparam int unsigned MAX_BYTES = MAX_TX_BYTES_DEF;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam logic [7:0] VARINT_PFX_8 = 8'hff;

	class tx_length_scoreboard;
		typedef struct packed {
			logic             ok;
			logic [LEN_W-1:0] len;
		} tx_result_t;

		phase_t      phase;
		logic [63:0] fixed_left;
		logic [63:0] vint_val;
		logic [63:0] items_left;
		int unsigned vint_left;
		int unsigned vint_pos;
		int unsigned consumed;
		int unsigned seen;
		bit          done;
		bit          overflow;
		tx_result_t  results_due[$];
		int          errors;

		function new();
			errors = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			phase = PH_VERSION;
			fixed_left = VERSION_BYTES;
			vint_val = '0;
			vint_left = 0;
			vint_pos = 0;
			items_left = '0;
			consumed = 0;
			seen = 0;
			done = 0;
			overflow = 0;
		endfunction

		function void start_fixed(phase_t p, logic [63:0] n);
			phase = p;
			fixed_left = n;
		endfunction

		function void start_varint(phase_t p);
			phase = p;
			vint_val = '0;
			vint_left = 0;
			vint_pos = 0;
		endfunction

		function void end_fixed();
			case (phase)
				PH_VERSION:   start_varint(PH_IN_COUNT);
				PH_IN_HEAD:   start_varint(PH_IN_SLEN);
				PH_IN_SCRIPT: start_fixed(PH_IN_SEQ, IN_SEQ_BYTES);
				PH_IN_SEQ: begin
					items_left = items_left - 1;
					if (items_left != 0) start_fixed(PH_IN_HEAD, IN_HEAD_BYTES);
					else start_varint(PH_OUT_COUNT);
				end
				PH_OUT_AMT:   start_varint(PH_OUT_SLEN);
				PH_OUT_SCRIPT: begin
					items_left = items_left - 1;
					if (items_left != 0) start_fixed(PH_OUT_AMT, OUT_AMT_BYTES);
					else start_fixed(PH_LOCKTIME, LOCKTIME_BYTES);
				end
				PH_LOCKTIME: begin
					phase = PH_DONE;
					done = 1;
				end
				default:      phase = PH_DONE;
			endcase
		endfunction

		function void end_varint(logic [63:0] v);
			case (phase)
				PH_IN_COUNT: begin
					items_left = v;
					if (v != 0) start_fixed(PH_IN_HEAD, IN_HEAD_BYTES);
					else start_varint(PH_OUT_COUNT);
				end
				PH_IN_SLEN: begin
					start_fixed(PH_IN_SCRIPT, v);
					if (v == 0) end_fixed();
				end
				PH_OUT_COUNT: begin
					items_left = v;
					if (v != 0) start_fixed(PH_OUT_AMT, OUT_AMT_BYTES);
					else start_fixed(PH_LOCKTIME, LOCKTIME_BYTES);
				end
				default: begin
					start_fixed(PH_OUT_SCRIPT, v);
					if (v == 0) end_fixed();
				end
			endcase
		endfunction

		function void parse_byte(logic [7:0] b);
			case (phase)
				PH_IN_COUNT, PH_IN_SLEN, PH_OUT_COUNT, PH_OUT_SLEN: begin
					if (vint_left == 0) begin
						if (b < VARINT_PFX_2) begin
							end_varint({56'd0, b});
						end else begin
							vint_left = (b == VARINT_PFX_2) ? VARINT_LEN_2 :
								(b == VARINT_PFX_4) ? VARINT_LEN_4 : VARINT_LEN_8;
							vint_pos = 0;
							vint_val = '0;
						end
					end else begin
						vint_val = vint_val | ({56'd0, b} << ((8 * vint_pos) & 63));
						vint_pos++;
						vint_left--;
						if (vint_left == 0) end_varint(vint_val);
					end
				end
				PH_DONE: ;
				default: begin
					if (fixed_left != 0) fixed_left = fixed_left - 1;
					if (fixed_left == 0) end_fixed();
				end
			endcase
		endfunction

		function void note_request(logic [7:0] b, logic last);
			tx_result_t r;
			if (seen >= MAX_BYTES) overflow = 1;
			else seen++;
			if (!overflow && !done) begin
				consumed++;
				parse_byte(b);
			end
			if (last) begin
				r.ok = done && !overflow;
				r.len = r.ok ? consumed[LEN_W-1:0] : '0;
				results_due.push_back(r);
				clear_parse();
			end
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] d);
			tx_result_t r;
			if (results_due.size() == 0) begin
				$error("result with none pending: tdata %h", d);
				errors++;
				return;
			end
			r = results_due.pop_front();
			if (d[0] !== r.ok) begin
				$error("tx_valid expected %0d actual %0d", r.ok, d[0]);
				errors++;
			end
			if (d[LEN_W:1] !== r.len) begin
				$error("tx_length expected %0d actual %0d", r.len, d[LEN_W:1]);
				errors++;
			end
			if (d[OUT_TDATA_W-1:LEN_W+1] !== '0) begin
				$error("pad expected 0 actual %h", d[OUT_TDATA_W-1:LEN_W+1]);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	tx_length_scoreboard sb;
	logic [7:0]  tx_bytes[$];
	int unsigned bytes_sent = 0;
	int unsigned buffers_sent = 0;
	int unsigned rx_gap_max = 12;
	int unsigned rx_hold = 0;
	int unsigned cycle_count = 0;

	bitcoin_tx_length_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bitcoin_tx_length_parser test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_request(s_tdata, s_tlast);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
		end
	end

	// result side: random stalls, one long hold on request
	initial begin
		int unsigned n;
		m_tready = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold != 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = $urandom_range(0, rx_gap_max);
			end
			if (n > 0) begin
				@(negedge clk);
				m_tready <= 0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_byte(logic [7:0] b, logic last, int unsigned gap_max);
		int unsigned n;
		n = $urandom_range(0, gap_max);
		if (n > 0) begin
			@(negedge clk);
			s_tvalid <= 0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_buffer(int unsigned gap_max);
		int k;
		for (k = 0; k < tx_bytes.size(); k++) begin
			send_byte(tx_bytes[k], k == tx_bytes.size() - 1, gap_max);
			bytes_sent++;
		end
		buffers_sent++;
	endtask

	function automatic void put_random(int unsigned n);
		repeat (n) tx_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	// random choice of compact-size encoding, long forms included
	function automatic void put_varint(logic [63:0] v);
		int unsigned sel;
		int unsigned nb;
		int i;
		sel = (v < VARINT_PFX_2) ? $urandom_range(0, 7) : $urandom_range(5, 7);
		if (sel < 5) begin
			tx_bytes.push_back(v[7:0]);
		end else begin
			nb = (sel == 5) ? VARINT_LEN_2 : (sel == 6) ? VARINT_LEN_4 : VARINT_LEN_8;
			tx_bytes.push_back((sel == 5) ? VARINT_PFX_2 :
				(sel == 6) ? VARINT_PFX_4 : VARINT_PFX_8);
			for (i = 0; i < nb; i++) tx_bytes.push_back(v[8*i +: 8]);
		end
	endfunction

	function automatic void build_tx();
		int unsigned n_in;
		int unsigned n_out;
		int unsigned slen;
		tx_bytes.delete();
		put_random(4);
		n_in = $urandom_range(0, 2);
		put_varint(64'(n_in));
		repeat (n_in) begin
			put_random(36);
			slen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			put_varint(64'(slen));
			put_random(slen);
			put_random(4);
		end
		n_out = $urandom_range(0, 2);
		put_varint(64'(n_out));
		repeat (n_out) begin
			put_random(8);
			slen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			put_varint(64'(slen));
			put_random(slen);
		end
		put_random(4);
	endfunction

	initial begin
		int unsigned kind;
		int unsigned cut;
		int unsigned gap_max;
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1;

		// truncated in the version field
		tx_bytes = '{8'hff};
		send_buffer(12);
		// zero counts with a trailing byte
		tx_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'hab};
		send_buffer(12);
		// cut inside a compact-size value
		tx_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hfd, 8'h12};
		send_buffer(12);
		tx_bytes = '{8'h01, 8'h02, 8'h03, 8'h04, 8'hfe, 8'hff};
		send_buffer(12);

		while (bytes_sent < 560) begin
			kind = $urandom_range(0, 9);
			build_tx();
			if (kind <= 5) begin
				if ($urandom_range(0, 2) == 0) put_random($urandom_range(1, 5));
			end else if (kind <= 7) begin
				cut = $urandom_range(1, tx_bytes.size() - 1);
				while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
			end else if (kind == 8) begin
				tx_bytes.delete();
				put_random($urandom_range(1, 30));
			end else begin
				// script length far beyond the buffer
				tx_bytes.delete();
				put_random(4);
				tx_bytes.push_back(8'd1);
				put_random(36);
				tx_bytes.push_back(VARINT_PFX_8);
				put_random(7);
				tx_bytes.push_back(8'($urandom_range(1, 255)));
				put_random($urandom_range(0, 10));
			end
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
			send_buffer(gap_max);
		end

		// receiver holds off while short buffers keep coming
		rx_gap_max = 12;
		rx_hold = 400;
		repeat (20) begin
			if ($urandom_range(0, 1) == 0) begin
				tx_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
					8'h00, 8'h00, 8'h00, 8'h00};
			end else begin
				tx_bytes.delete();
				put_random($urandom_range(1, 3));
			end
			send_buffer(0);
		end

		@(negedge clk);
		s_tvalid <= 0;
		s_tlast <= 0;
		while (sb.results_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("bitcoin_tx_length_parser test passed");
		end else begin
			$display("bitcoin_tx_length_parser test failed");
		end
		$finish;
	end

endmodule

// ----- bitcoin_tx_length_parser.f -----
+incdir+hw/rtl
hw/rtl/btxlp_pkg.sv
hw/rtl/btxlp_core.sv
hw/rtl/bitcoin_tx_length_parser.sv
dv/bitcoin_tx_length_parser_tb.sv
